FILE: design/isrt_pkg.sv
// Package for the insertion sorter: shared data type and the
// command/status structs between controller and datapath. No dependencies.
package isrt_pkg;

  localparam int unsigned DataW = 32;

  typedef logic signed [DataW-1:0] data_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } isrt_cmd_t;

  typedef struct packed {
    logic last;
  } isrt_stat_t;

endpackage

FILE: design/isrt_ctrl.sv
// Controller for the insertion sorter: collect/emit state machine.
// Depends on isrt_pkg.
module isrt_ctrl import isrt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       set_end_i,
  input  logic       out_ready_i,
  input  isrt_stat_t stat_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  output isrt_cmd_t  cmd_o
);

  typedef enum logic {
    StCollect,
    StEmit
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   in_beat;
  logic   out_beat;

  assign in_beat  = in_valid_i & in_ready_q;
  assign out_beat = out_valid_q & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StCollect;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StCollect: begin
          if (in_beat && set_end_i) begin
            state_q     <= StEmit;
            in_ready_q  <= 1'b0;
            out_valid_q <= 1'b1;
          end
        end
        StEmit: begin
          if (out_beat && stat_i.last) begin
            state_q     <= StCollect;
            in_ready_q  <= 1'b1;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= StCollect;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o   = in_ready_q;
  assign out_valid_o  = out_valid_q;
  assign cmd_o.insert = in_beat;
  assign cmd_o.pop    = out_beat;

endmodule

FILE: design/isrt_dpath.sv
// Datapath for the insertion sorter: row of compare cells holding the set
// in ascending order, count and drop flag. Depends on isrt_pkg.
module isrt_dpath import isrt_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  isrt_cmd_t  cmd_i,
  input  data_t      sample_value_i,
  output isrt_stat_t stat_o,
  output data_t      sorted_value_o,
  output logic       run_end_o,
  output logic       overflowed_o
);

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

  data_t          store_q [MAX_ITEMS];
  data_t          store_d [MAX_ITEMS];
  logic [CntW-1:0] count_q, count_d;
  logic           drop_q, drop_d;
  logic [MAX_ITEMS-1:0] gt;
  logic           full;

  assign full = (count_q == CntW'(MAX_ITEMS));

  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    assign gt[k] = (CntW'(k) < count_q) && (store_q[k] > sample_value_i);

    always_comb begin
      store_d[k] = store_q[k];
      if (cmd_i.pop) begin
        if (k < MAX_ITEMS - 1) begin
          store_d[k] = store_q[(k < MAX_ITEMS - 1) ? k + 1 : k];
        end
      end else if (cmd_i.insert && !full) begin
        if (k > 0 && gt[(k > 0) ? k - 1 : 0]) begin
          store_d[k] = store_q[(k > 0) ? k - 1 : 0];
        end else if (gt[k] || CntW'(k) == count_q) begin
          store_d[k] = sample_value_i;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      store_q[k] <= store_d[k];
    end
  end

  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    if (cmd_i.pop) begin
      count_d = count_q - CntW'(1);
      if (stat_o.last) begin
        drop_d = 1'b0;
      end
    end else if (cmd_i.insert) begin
      if (full) begin
        drop_d = 1'b1;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      drop_q  <= drop_d;
    end
  end

  assign stat_o.last    = (count_q == CntW'(1));
  assign sorted_value_o = store_q[0];
  assign run_end_o      = stat_o.last;
  assign overflowed_o   = drop_q;

endmodule

FILE: design/insertion_sorter.sv
// Insertion sorter for sets of signed 32-bit values, stable ascending.
// Built from isrt_ctrl and isrt_dpath; depends on isrt_pkg.
//
// Input channel: one value per beat on sample_value_i; set_end_i marks the
// last value of a set. Each beat is inserted by a row of compare cells, so a
// set is collected at one value per cycle.
// Output channel: after the set_end beat the set leaves head first, one
// value per cycle while out_ready_i is high; run_end_o marks the largest
// value and overflowed_o is high on every beat of a set that lost values
// because more than MAX_ITEMS arrived.
// The first result is valid the cycle after the set_end beat.
// A set keeps at most MAX_ITEMS values; input is not accepted while a set is
// being emitted and is ready again the cycle after the run_end beat.
// A receiver stall holds the current result and freezes the cell row.
// Reset empties the set and clears the overflow flag; input is ready.
module insertion_sorter import isrt_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  data_t sample_value_i,
  input  logic  set_end_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output data_t sorted_value_o,
  output logic  run_end_o,
  output logic  overflowed_o
);

  isrt_cmd_t  cmd;
  isrt_stat_t stat;

  isrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .set_end_i  (set_end_i),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .cmd_o      (cmd)
  );

  isrt_dpath #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sample_value_i(sample_value_i),
    .stat_o        (stat),
    .sorted_value_o(sorted_value_o),
    .run_end_o     (run_end_o),
    .overflowed_o  (overflowed_o)
  );

endmodule

FILE: design/isrt_checker.sv
// Port-level checker for the insertion sorter and its bind to the top.
// Depends on isrt_pkg.
module isrt_checker import isrt_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_o,
  input logic  set_end_i,
  input logic  out_valid_o,
  input logic  out_ready_i,
  input data_t sorted_value_o,
  input logic  run_end_o,
  input logic  overflowed_o
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while emitting");

  a_emit_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && set_end_i |=> out_valid_o)
    else $error("no result after set end");

  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !run_end_o |=>
      out_valid_o && (sorted_value_o >= $past(sorted_value_o)) &&
      (overflowed_o == $past(overflowed_o)))
    else $error("set broken or out of order");

  a_set_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && run_end_o |=> in_ready_o && !out_valid_o)
    else $error("block not ready after last beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sorted_value_o))
    else $error("stalled result changed");

endmodule

bind insertion_sorter isrt_checker u_isrt_checker (.*);
